// ===== hdl/rapqt_pkg.sv =====
package rapqt_pkg;

  // tree geometry
  localparam int LEAVES = 1024;
  localparam int NODES  = 2 * LEAVES;
  localparam int LEAF_W = $clog2(LEAVES);
  // node address into the store (0-based heap order)
  localparam int ADDR_W = $clog2(NODES);
  // 1-based node index, wide enough to hold NODES itself
  localparam int IDX_W  = ADDR_W + 1;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ADD   = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ADD_SCAN,
    ST_ADD_WR,
    ST_QUERY,
    ST_QDRAIN
  } state_t;

endpackage

// ===== hdl/range_add_point_query_tree.sv =====
// Segment tree over LEAVES leaves with range add and point query.
//
// Input channel: an item (in_opcode, in_left_index, in_right_end,
// in_operand_value) is taken at a rising edge with start high and busy low.
// Clear writes identity_value into every node, load writes one leaf, range
// add adds into the nodes covering [left_index, right_end), query sums the
// nodes from the leaf up to the root.
// Result channel: a query gives one beat on out_point_sum, marked by
// out_valid for exactly one cycle; the receiver always takes it.
// Config: cfg_we/cfg_wdata write identity_value, taken at any edge.
//
// Timing: a load writes its leaf in the accept cycle and the block stays idle.
// A query reads one node per cycle from the node store, LEAF_W+1 reads, and
// out_valid goes high in the same cycle as busy falls, so the next item can
// be taken in the cycle of the result beat. A range add does a read-modify-write
// per covered node, reading in ST_ADD_SCAN and writing in ST_ADD_WR, and climbs
// one tree level in ST_ADD_SCAN when neither edge is odd. Clear sweeps the store
// one node a cycle over every node address.
// Reset: the same sweep runs with zero, with busy high.
module range_add_point_query_tree
  import rapqt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic [9:0]               in_left_index,
  input  logic [10:0]              in_right_end,
  input  logic signed [31:0]       in_operand_value,
  output logic                     out_valid,
  output logic signed [31:0]       out_point_sum,
  input  logic                     cfg_we,
  input  logic signed [31:0]       cfg_wdata
);

  state_t              state_r, state_nxt;
  logic [DATA_W-1:0]   ident_r;
  logic [DATA_W-1:0]   sweep_val_r, sweep_val_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    lo_r, lo_nxt;
  logic [IDX_W-1:0]    hi_r, hi_nxt;
  logic [IDX_W-1:0]    tgt_r, tgt_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                rd_pend_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_sum_r;

  // node store
  logic [DATA_W-1:0]   mem [NODES];
  logic [DATA_W-1:0]   rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                accept;
  opcode_t             op;
  logic [LEAF_W-1:0]   leaf;
  logic [LEAF_W:0]     r_clamp;
  logic [IDX_W-1:0]    scan_tgt;
  logic [IDX_W-1:0]    hi_dec;

  assign accept  = start && (state_r == ST_IDLE);
  assign op      = opcode_t'(in_opcode);
  assign leaf    = in_left_index[LEAF_W-1:0];
  assign r_clamp = (in_right_end > 11'(LEAVES)) ? (LEAF_W+1)'(LEAVES) : in_right_end;
  assign hi_dec  = hi_r - IDX_W'(1);
  // next covered node: left edge first, then right edge
  assign scan_tgt = lo_r[0] ? lo_r : hi_dec;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
    end else if (cfg_we) begin
      ident_r <= cfg_wdata;
    end
  end

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    sweep_val_nxt = sweep_val_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    tgt_nxt       = tgt_r;
    val_nxt       = val_r;
    acc_nxt       = rd_pend_r ? (acc_r + rdata_r) : acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_CLEAR: begin
              state_nxt     = ST_SWEEP;
              sweep_val_nxt = ident_r;
              cnt_nxt       = '0;
            end
            OP_LOAD: begin
              state_nxt = ST_IDLE;
            end
            OP_ADD: begin
              state_nxt = ST_ADD_SCAN;
              lo_nxt    = IDX_W'(LEAVES) + IDX_W'(in_left_index);
              hi_nxt    = IDX_W'(LEAVES) + IDX_W'(r_clamp);
              val_nxt   = in_operand_value;
            end
            OP_QUERY: begin
              state_nxt = ST_QUERY;
              tgt_nxt   = IDX_W'(LEAVES) + IDX_W'(leaf);
              acc_nxt   = '0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        cnt_nxt = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD_SCAN: begin
        priority if (lo_r >= hi_r) begin
          state_nxt = ST_IDLE;
        end else if (lo_r[0]) begin
          tgt_nxt   = scan_tgt;
          lo_nxt    = lo_r + IDX_W'(1);
          state_nxt = ST_ADD_WR;
        end else if (hi_r[0]) begin
          tgt_nxt   = scan_tgt;
          hi_nxt    = hi_dec;
          state_nxt = ST_ADD_WR;
        end else begin
          lo_nxt = lo_r >> 1;
          hi_nxt = hi_r >> 1;
        end
      end
      ST_ADD_WR: begin
        state_nxt = ST_ADD_SCAN;
      end
      ST_QUERY: begin
        tgt_nxt = tgt_r >> 1;
        if (tgt_r == IDX_W'(1)) begin
          state_nxt = ST_QDRAIN;
        end
      end
      ST_QDRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    busy      = (state_r != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = tgt_r[ADDR_W-1:0] - ADDR_W'(1);
    mem_wdata = rdata_r + val_r;
    mem_raddr = tgt_r[ADDR_W-1:0] - ADDR_W'(1);
    unique case (state_r)
      ST_IDLE: begin
        mem_we    = accept && (op == OP_LOAD);
        mem_waddr = ADDR_W'(LEAVES - 1) + ADDR_W'(leaf);
        mem_wdata = in_operand_value;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = sweep_val_r;
      end
      ST_ADD_SCAN: begin
        mem_raddr = scan_tgt[ADDR_W-1:0] - ADDR_W'(1);
      end
      ST_ADD_WR: begin
        mem_we = 1'b1;
      end
      ST_QUERY: begin
        mem_raddr = tgt_r[ADDR_W-1:0] - ADDR_W'(1);
      end
      ST_QDRAIN: begin
        mem_we = 1'b0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // node store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_val_r <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_val_r <= sweep_val_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= (state_r == ST_QUERY);
      out_valid_r <= (state_r == ST_QDRAIN);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    tgt_r <= tgt_nxt;
    val_r <= val_nxt;
    acc_r <= acc_nxt;
    if (state_r == ST_QDRAIN) begin
      out_sum_r <= acc_r + rdata_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_point_sum = out_sum_r;

`ifndef NO_ASSERTIONS
  // a result beat only follows the last root read of a query
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_QDRAIN))
    else $error("result beat without finished query");

  // a query never disturbs the node store
  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUERY || state_r == ST_QDRAIN) |-> !mem_we)
    else $error("store written during query");

  // an exhausted range ends the add
  a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_SCAN && lo_r >= hi_r) |=> (state_r == ST_IDLE))
    else $error("range add did not finish");

  // every add write is preceded by its read of the same node
  a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_WR) |-> $past(state_r == ST_ADD_SCAN))
    else $error("add write without read");
`endif

endmodule
